// File: rtl/cvta_pkg.sv
// ----------------------------------------------------------------------------
// cvta_pkg
// Shared types, constants and tables for the turn angle block.
// ----------------------------------------------------------------------------
package cvta_pkg;

   localparam int unsigned JOINT_W   = 5;
   localparam int unsigned COMP_W    = 16;
   localparam int unsigned VEC_W     = 3 * COMP_W;
   localparam int unsigned ANGLE_W   = 16;
   localparam int unsigned REQ_W     = 56;
   localparam int unsigned RSP_W     = 24;
   localparam int unsigned Z_W       = 24;
   localparam int unsigned ATAN_W    = 21;
   localparam int unsigned CORDIC_N  = 20;
   localparam int unsigned MUL_OPS   = 12;
   localparam int unsigned SQRT_N    = 32;

   localparam logic [ANGLE_W-1:0] PI_Q14      = 16'd51472;
   localparam logic signed [Z_W-1:0] HALF_PI_Q20 = 24'sd1647099;

   // one request as it travels from the front to the back
   typedef struct packed {
      logic [JOINT_W-1:0] joint;
      logic [VEC_W-1:0]   cur;    // x in the low bits
      logic [VEC_W-1:0]   prev;   // x in the low bits
      logic               calc;   // angle must be computed
   } entry_type;

   function automatic logic [ATAN_W-1:0] atan_q20(input logic [4:0] i);
      logic [ATAN_W-1:0] v;
      case (i)
         5'd0:    v = 21'd823550;
         5'd1:    v = 21'd486170;
         5'd2:    v = 21'd256879;
         5'd3:    v = 21'd130396;
         5'd4:    v = 21'd65451;
         5'd5:    v = 21'd32757;
         5'd6:    v = 21'd16383;
         5'd7:    v = 21'd8192;
         5'd8:    v = 21'd4096;
         5'd9:    v = 21'd2048;
         5'd10:   v = 21'd1024;
         5'd11:   v = 21'd512;
         5'd12:   v = 21'd256;
         5'd13:   v = 21'd128;
         5'd14:   v = 21'd64;
         5'd15:   v = 21'd32;
         5'd16:   v = 21'd16;
         5'd17:   v = 21'd8;
         5'd18:   v = 21'd4;
         5'd19:   v = 21'd2;
         default: v = 21'd0;
      endcase
      return v;
   endfunction

   // magnitude of a cross product component, at most 2^31
   function automatic logic [31:0] mag34(input logic signed [33:0] v);
      logic signed [33:0] m;
      m = v[33] ? -v : v;
      return m[31:0];
   endfunction

   // Q20 angle to Q14, clamped to 0..pi
   function automatic logic [ANGLE_W-1:0] angle_q14(input logic signed [Z_W-1:0] z);
      logic [Z_W-1:0] r;
      logic [Z_W-1:0] q;
      r = $unsigned(z) + 24'd32;
      q = r >> 6;
      if (z[Z_W-1]) begin
         return '0;
      end else if (q > {8'd0, PI_Q14}) begin
         return PI_Q14;
      end
      return q[ANGLE_W-1:0];
   endfunction

endpackage

// File: rtl/consecutive_vector_turn_angle.sv
// ----------------------------------------------------------------------------
// consecutive_vector_turn_angle
// Per-joint turn angle between consecutive 3D velocity vectors.
// ----------------------------------------------------------------------------
// A request that needs an angle runs through 13 multiply steps, 32 square
//   root steps and 20 CORDIC steps (none for a zero norm); others skip these.
// The back end's single multiplier, square root and CORDIC sequence serve one
//   request at a time; the front takes no request while its stage is full.
// Reset: synchronous; clears frame counts, queue and handshake state.
module consecutive_vector_turn_angle
   import cvta_pkg::*;
#(
   parameter int MAX_JOINTS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // joint, vel_x, vel_y, vel_z, zero pad
   input  logic             req_tuser,   // restart
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // joint_out, turn_angle, zero pad
);

   entry_type push_entry;
   entry_type head;
   logic      push, pop, empty, full;

   cvta_front #(
      .MAX_JOINTS (MAX_JOINTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_push     (push),
      .q_entry    (push_entry),
      .q_full     (full)
   );

   cvta_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   cvta_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (head),
      .q_empty    (empty),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// File: rtl/cvta_front.sv
// ----------------------------------------------------------------------------
// cvta_front
// Accepts requests, keeps per-joint history and frame counts, classifies.
// ----------------------------------------------------------------------------
module cvta_front
   import cvta_pkg::*;
#(
   parameter int MAX_JOINTS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             req_tuser,
   output logic             q_push,
   output entry_type        q_entry,
   input  logic             q_full
);

   localparam int IDX_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

   logic [VEC_W-1:0]   mem [MAX_JOINTS];
   logic [VEC_W-1:0]   prev_rd_ff;
   logic [1:0]         fs_ff [MAX_JOINTS];
   logic               s1_vld_ff, s1_vld_in;
   logic [JOINT_W-1:0] s1_joint_ff;
   logic [VEC_W-1:0]   s1_cur_ff;
   logic               s1_calc_ff;

   logic [JOINT_W-1:0] joint;
   logic [IDX_W-1:0]   idx;
   logic               in_range;
   logic               accept;
   logic [1:0]         seen;

   assign joint      = req_tdata[JOINT_W-1:0];
   assign idx        = IDX_W'(joint);
   assign in_range   = ({27'd0, joint} < 32'(MAX_JOINTS));
   assign req_tready = !s1_vld_ff && !q_full;
   assign accept     = req_tvalid && req_tready;
   assign seen       = req_tuser ? 2'd0 : fs_ff[idx];
   assign s1_vld_in  = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         for (int j = 0; j < MAX_JOINTS; j++) begin
            fs_ff[j] <= 2'd0;
         end
      end else begin
         s1_vld_ff <= s1_vld_in;
         if (accept && in_range) begin
            fs_ff[idx] <= (seen == 2'd2) ? 2'd2 : seen + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_joint_ff <= joint;
         s1_cur_ff   <= req_tdata[JOINT_W +: VEC_W];
         s1_calc_ff  <= in_range && (seen == 2'd2);
         prev_rd_ff  <= mem[idx];
         if (in_range) begin
            mem[idx] <= req_tdata[JOINT_W +: VEC_W];
         end
      end
   end

   assign q_push        = s1_vld_ff;
   assign q_entry.joint = s1_joint_ff;
   assign q_entry.cur   = s1_cur_ff;
   assign q_entry.prev  = prev_rd_ff;
   assign q_entry.calc  = s1_calc_ff;

endmodule

// File: rtl/cvta_queue.sv
// ----------------------------------------------------------------------------
// cvta_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module cvta_queue
   import cvta_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output entry_type head,
   output logic      empty,
   output logic      full
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign empty = (cnt_ff == 2'd0);
   assign full  = (cnt_ff == 2'd2);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: rtl/cvta_back.sv
// ----------------------------------------------------------------------------
// cvta_back
// Products on a shared multiplier, bit-serial square root, CORDIC atan2.
// ----------------------------------------------------------------------------
module cvta_back
   import cvta_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  entry_type        q_head,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_SQRT = 5'b00100,
      ST_CORD = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type          st_ff, st_in;
   logic [4:0]         cnt_ff, cnt_in;
   entry_type          item_ff;
   logic signed [63:0] prod_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic signed [34:0] dot_ff;
   logic [63:0]        sum_ff;
   logic [34:0]        rem_ff;
   logic [31:0]        root_ff;
   logic signed [35:0] x_ff, y_ff;
   logic signed [Z_W-1:0] z_ff;
   logic [ANGLE_W-1:0] ang_ff;
   logic               rsp_tvalid_ff;
   logic [RSP_W-1:0]   rsp_tdata_ff;

   logic signed [31:0] op_a, op_b;
   logic signed [15:0] ax, ay, az, bx, by, bz;
   logic [34:0]        rem_sh, trial;
   logic [34:0]        rem_in;
   logic [31:0]        root_in;
   logic signed [35:0] xs, ys, x_in, y_in;
   logic signed [Z_W-1:0] z_in, atan_s;
   logic               out_free;

   assign ax = $signed(item_ff.cur[15:0]);
   assign ay = $signed(item_ff.cur[31:16]);
   assign az = $signed(item_ff.cur[47:32]);
   assign bx = $signed(item_ff.prev[15:0]);
   assign by = $signed(item_ff.prev[31:16]);
   assign bz = $signed(item_ff.prev[47:32]);

   assign q_pop      = (st_ff == ST_IDLE) && !q_empty;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   always_comb begin
      case (cnt_ff)
         5'd0:    begin op_a = 32'(ay); op_b = 32'(bz); end
         5'd1:    begin op_a = 32'(az); op_b = 32'(by); end
         5'd2:    begin op_a = 32'(az); op_b = 32'(bx); end
         5'd3:    begin op_a = 32'(ax); op_b = 32'(bz); end
         5'd4:    begin op_a = 32'(ax); op_b = 32'(by); end
         5'd5:    begin op_a = 32'(ay); op_b = 32'(bx); end
         5'd6:    begin op_a = 32'(ax); op_b = 32'(bx); end
         5'd7:    begin op_a = 32'(ay); op_b = 32'(by); end
         5'd8:    begin op_a = 32'(az); op_b = 32'(bz); end
         5'd9:    begin op_a = $signed(mag34(cx_ff)); op_b = $signed(mag34(cx_ff)); end
         5'd10:   begin op_a = $signed(mag34(cy_ff)); op_b = $signed(mag34(cy_ff)); end
         5'd11:   begin op_a = $signed(mag34(cz_ff)); op_b = $signed(mag34(cz_ff)); end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   always_comb begin
      rem_sh = {rem_ff[32:0], sum_ff[63:62]};
      trial  = {1'b0, root_ff, 2'b01};
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {root_ff[30:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {root_ff[30:0], 1'b0};
      end
   end

   always_comb begin
      xs     = x_ff >>> cnt_ff;
      ys     = y_ff >>> cnt_ff;
      atan_s = $signed({3'd0, atan_q20(cnt_ff)});
      if (y_ff > 36'sd0) begin
         x_in = x_ff + ys;
         y_in = y_ff - xs;
         z_in = z_ff + atan_s;
      end else begin
         x_in = x_ff - ys;
         y_in = y_ff + xs;
         z_in = z_ff - atan_s;
      end
   end

   always_comb begin
      st_in  = st_ff;
      cnt_in = cnt_ff;
      case (st_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               st_in  = q_head.calc ? ST_MUL : ST_DONE;
               cnt_in = 5'd0;
            end
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(MUL_OPS)) begin
               st_in  = ST_SQRT;
               cnt_in = 5'd0;
            end
         end
         ST_SQRT: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(SQRT_N - 1)) begin
               st_in  = (root_in == 32'd0) ? ST_DONE : ST_CORD;
               cnt_in = 5'd0;
            end
         end
         ST_CORD: begin
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(CORDIC_N - 1)) begin
               st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= ST_IDLE;
         cnt_ff        <= 5'd0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         if (st_ff == ST_DONE && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         ST_IDLE: begin
            item_ff <= q_head;
            cx_ff   <= '0;
            cy_ff   <= '0;
            cz_ff   <= '0;
            dot_ff  <= '0;
            sum_ff  <= '0;
            rem_ff  <= '0;
            root_ff <= '0;
            ang_ff  <= '0;
         end
         ST_MUL: begin
            prod_ff <= op_a * op_b;
            case (cnt_ff)
               5'd1:    cx_ff  <= cx_ff + 34'(prod_ff);
               5'd2:    cx_ff  <= cx_ff - 34'(prod_ff);
               5'd3:    cy_ff  <= cy_ff + 34'(prod_ff);
               5'd4:    cy_ff  <= cy_ff - 34'(prod_ff);
               5'd5:    cz_ff  <= cz_ff + 34'(prod_ff);
               5'd6:    cz_ff  <= cz_ff - 34'(prod_ff);
               5'd7,
               5'd8,
               5'd9:    dot_ff <= dot_ff + 35'(prod_ff);
               5'd10,
               5'd11,
               5'd12:   sum_ff <= sum_ff + $unsigned(prod_ff);
               default: ;
            endcase
         end
         ST_SQRT: begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            sum_ff  <= {sum_ff[61:0], 2'b00};
            if (cnt_ff == 5'(SQRT_N - 1)) begin
               if (root_in == 32'd0) begin
                  ang_ff <= dot_ff[34] ? PI_Q14 : '0;
               end else if (dot_ff[34]) begin
                  x_ff <= $signed({4'd0, root_in});
                  y_ff <= -36'(dot_ff);
                  z_ff <= HALF_PI_Q20;
               end else begin
                  x_ff <= 36'(dot_ff);
                  y_ff <= $signed({4'd0, root_in});
                  z_ff <= '0;
               end
            end
         end
         ST_CORD: begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= z_in;
            if (cnt_ff == 5'(CORDIC_N - 1)) begin
               ang_ff <= angle_q14(z_in);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_tdata_ff <= {3'd0, ang_ff, item_ff.joint};
            end
         end
         default: ;
      endcase
   end

endmodule

// File: rtl/cvta_checker.sv
// ----------------------------------------------------------------------------
// cvta_checker
// Port-level checks for the turn angle block.
// ----------------------------------------------------------------------------
module cvta_checker
   import cvta_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response dropped or changed while stalled");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[20:5] <= PI_Q14)
      else $error("turn angle above pi");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:21] == 3'd0)
      else $error("response padding not zero");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted on consecutive cycles");

endmodule

bind consecutive_vector_turn_angle cvta_checker u_cvta_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
